### src/mdlr_pkg.sv
`default_nettype none
package mdlr_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int MAX_CHANNELS = 8;
  localparam int CHAN_PORTS   = 8;
  localparam int CH_W         = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W        = SAMPLE_W + CH_W;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
  localparam int FIFO_DEPTH   = 16384;
  localparam int ADDR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = 15;
  localparam int FRAC_W       = 27;
  localparam int POS_W        = 34;
  localparam int POS_INT_W    = POS_W - FRAC_W;
  localparam int STEP_W       = 32;
  localparam int DIFF_W       = SAMPLE_W + 1;
  localparam int PLO_W        = 16 + FRAC_W;
  localparam int PHI_W        = (DIFF_W - 16) + FRAC_W + 1;
  localparam int PROD_W       = DIFF_W + FRAC_W + 1;
  localparam int NORM_STEPS   = $clog2(SAMPLE_W);
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [1:0] {
    FMT_PCM16 = 2'd0,
    FMT_PCM24 = 2'd1,
    FMT_PCM32 = 2'd2,
    FMT_F32   = 2'd3
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPTURE_FORMAT   = 3'd0,
    CFG_CAPTURE_CHANNELS = 3'd1,
    CFG_RENDER_FORMAT    = 3'd2,
    CFG_STEP_RATIO       = 3'd3,
    CFG_MAX_QUEUED       = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CAP_SUM,
    ST_CAP_WAIT,
    ST_CAP_PUSH,
    ST_R_TRIM,
    ST_R_DEBT0,
    ST_R_CHK,
    ST_R_RD0,
    ST_R_RD1,
    ST_R_MUL0,
    ST_R_MUL1,
    ST_R_MUL2,
    ST_R_MUL3,
    ST_R_ADV,
    ST_R_DEBT1,
    ST_R_ABS,
    ST_R_NORM,
    ST_ENC
  } top_st_e;

endpackage
`default_nettype wire

### src/mdlr_if.sv
`default_nettype none
interface mdlr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        silent;
  logic [31:0] chan0_word;
  logic [31:0] chan1_word;
  logic [31:0] chan2_word;
  logic [31:0] chan3_word;
  logic [31:0] chan4_word;
  logic [31:0] chan5_word;
  logic [31:0] chan6_word;
  logic [31:0] chan7_word;
  modport source (output valid, mode, silent, chan0_word, chan1_word, chan2_word,
                  chan3_word, chan4_word, chan5_word, chan6_word, chan7_word,
                  input ready);
  modport sink (input valid, mode, silent, chan0_word, chan1_word, chan2_word,
                chan3_word, chan4_word, chan5_word, chan6_word, chan7_word,
                output ready);
endinterface

interface mdlr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_word;
  logic [31:0] peak_level;
  logic [14:0] queued_count;
  modport source (output valid, sample_word, peak_level, queued_count, input ready);
  modport sink (input valid, sample_word, peak_level, queued_count, output ready);
endinterface

interface mdlr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/mdlr_ram.sv
`default_nettype none
module mdlr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### src/mdlr_lane.sv
`default_nettype none
module mdlr_lane import mdlr_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       load_i,
  input  wire fmt_e                       fmt_i,
  input  wire logic [SAMPLE_W-1:0]        word_i,
  output logic signed [SAMPLE_W-1:0]      val_o
);

  logic signed [SAMPLE_W-1:0] val_d, val_q;
  logic                       sgn;
  logic [7:0]                 ex;
  logic [23:0]                man;
  logic signed [9:0]          sh;
  logic [4:0]                 nsh;
  logic [SAMPLE_W-1:0]        mag;
  logic                       sat;

  // decode to Q1.31: PCM16 and PCM24 left-justified, PCM32 as is, float32 with saturation; NaN and subnormals give zero
  always_comb begin
    sgn = word_i[31];
    ex  = word_i[30:23];
    man = {1'b1, word_i[22:0]};
    sh  = $signed({2'b00, ex}) - 10'sd119;
    nsh = 5'(-sh);
    mag = '0;
    sat = 1'b0;
    if (ex == 8'hFF && word_i[22:0] != '0) begin
      mag = '0;
    end else if (ex == 8'h00) begin
      mag = '0;
    end else if (ex == 8'hFF || sh > 10'sd8) begin
      sat = 1'b1;
    end else if (sh >= 10'sd0) begin
      mag = SAMPLE_W'(man) << sh[3:0];
    end else if (sh > -10'sd32) begin
      mag = SAMPLE_W'(man) >> nsh;
    end
    if (sat || (sgn && mag[31]) || (!sgn && mag[31])) begin
      mag = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
      val_d = $signed(mag);
    end else begin
      val_d = sgn ? $signed(-mag) : $signed(mag);
    end
    unique case (fmt_i)
      FMT_PCM16: val_d = $signed({word_i[15:0], 16'h0000});
      FMT_PCM24: val_d = $signed({word_i[23:0], 8'h00});
      FMT_PCM32: val_d = $signed(word_i);
      FMT_F32:   val_d = val_d;
      default:   val_d = val_d;
    endcase
  end

  // hold the decoded word for the merge stage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

### src/mdlr_merge.sv
`default_nettype none
module mdlr_merge import mdlr_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          silent_i,
  input  wire logic [CH_W-1:0]               n_i,
  input  wire logic signed [SAMPLE_W-1:0]    vals_i [MAX_CHANNELS],
  output logic                               done_o,
  output logic [SAMPLE_W-1:0]                mono_o
);

  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic                    abs_q, neg_q, done_q;
  logic [SUM_W-1:0]        quo_q;
  logic [CH_W-1:0]         rem_q;
  logic [DIV_CNT_W-1:0]    cnt_q;
  logic [CH_W:0]           trial;
  logic                    ge;

  // add the active lanes
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (CH_W'(i) < n_i && !silent_i) begin
        sum_d = sum_d + SUM_W'(vals_i[i]);
      end
    end
  end

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, n_i};

  // sum, take magnitude, then divide one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        abs_q <= 1'b1;
      end else if (abs_q) begin
        abs_q <= 1'b0;
        cnt_q <= DIV_CNT_W'(SUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_d;
    end else if (abs_q) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? CH_W'(trial - {1'b0, n_i}) : trial[CH_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign mono_o = neg_q ? SAMPLE_W'(~quo_q + 1'b1) : quo_q[SAMPLE_W-1:0];

endmodule
`default_nettype wire

### src/mono_downmix_linear_resampler_core.sv
`default_nettype none
// Channel   Dir  Beat contents
// in_i      in   mode, silent, chan0_word .. chan7_word
// out_o     out  sample_word, peak_level, queued_count (render beats only)
// cfg_i     in   index, data
//
// A capture beat waits on the bit-serial divide by the channel count. A render
// beat that interpolates adds two FIFO reads through the single RAM read port
// and a two-part multiply.
// One beat is worked at a time; a pending result does not block capture beats.
// Reset clears control state; the FIFO RAM needs no clearing pass.
module mono_downmix_linear_resampler_core import mdlr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mdlr_in_if.sink   in_i,
  mdlr_out_if.source out_o,
  mdlr_cfg_if.sink  cfg_i
);

  top_st_e state_q, state_d;

  fmt_e                cap_fmt_q, ren_fmt_q;
  logic [3:0]          chans_q;
  logic [STEP_W-1:0]   step_q;
  logic [CNT_W-1:0]    maxq_q;

  logic [ADDR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [SAMPLE_W-1:0] peak_q, peak_d;

  logic                silent_q;
  logic [SAMPLE_W-1:0] mono_q, mono_d;
  logic [SAMPLE_W-1:0] s0_q, s0_d, sample_q, sample_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic [PLO_W-1:0]    plo_q, plo_d;
  logic signed [PHI_W-1:0]  phi_q, phi_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PROD_W-1:0] delta;
  logic                neg_q, neg_d;
  logic [SAMPLE_W-1:0] mag_q, mag_d, norm_q, norm_d;
  logic [5:0]          expo_q, expo_d;
  logic [2:0]          nstep_q, nstep_d;
  logic [5:0]          nsh;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_word_q, out_peak_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic                out_load;
  logic [SAMPLE_W-1:0] enc_word;

  logic                in_acc;
  logic [CNT_W-1:0]    cap;
  logic [CH_W-1:0]     n_ch;
  logic [6:0]          k;
  logic [CNT_W-1:0]    drop, keep_cnt;
  logic [ADDR_W-1:0]   push_head;
  logic [SAMPLE_W-1:0] pmag;
  logic                interp_ok;

  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [SAMPLE_W-1:0] rdata;

  logic [SAMPLE_W-1:0]        words [CHAN_PORTS];
  logic signed [SAMPLE_W-1:0] lane_val [MAX_CHANNELS];
  logic                       merge_start, merge_done;
  logic [SAMPLE_W-1:0]        merge_mono;

  function automatic logic [6:0] debt_k(logic [6:0] owed, logic [CNT_W-1:0] avail);
    return (avail < CNT_W'(owed)) ? avail[6:0] : owed;
  endfunction

  function automatic logic [SAMPLE_W-1:0] encode(fmt_e fmt, logic neg,
                                                 logic [SAMPLE_W-1:0] mag,
                                                 logic [SAMPLE_W-1:0] norm,
                                                 logic [5:0] expo);
    logic [46:0] p16;
    logic [54:0] p24;
    logic [62:0] p32;
    logic [16:0] q16;
    logic [24:0] q24;
    logic [24:0] qf;
    logic        up;
    logic [7:0]  ef;
    logic [SAMPLE_W-1:0] res;
    p16 = {mag, 15'h0} - 47'(mag);
    p24 = {mag, 23'h0} - 55'(mag);
    p32 = {mag, 31'h0} - 63'(mag);
    q16 = '0;
    q24 = '0;
    qf  = '0;
    up  = 1'b0;
    ef  = '0;
    res = '0;
    unique case (fmt)
      FMT_PCM16: begin
        if (neg) begin
          up  = mag[15:0] > 16'h8000 || (mag[15:0] == 16'h8000 && mag[16]);
          q16 = 17'(mag[31:16]) + 17'(up);
          res = {16'h0000, (~q16[15:0]) + 16'd1};
        end else begin
          up  = p16[30:0] > 31'h4000_0000 || (p16[30:0] == 31'h4000_0000 && p16[31]);
          res = 32'(p16[46:31]) + 32'(up);
        end
      end
      FMT_PCM24: begin
        if (neg) begin
          up  = mag[7:0] > 8'h80 || (mag[7:0] == 8'h80 && mag[8]);
          q24 = 25'(mag[31:8]) + 25'(up);
          res = {8'h00, (~q24[23:0]) + 24'd1};
        end else begin
          up  = p24[30:0] > 31'h4000_0000 || (p24[30:0] == 31'h4000_0000 && p24[31]);
          res = 32'(p24[54:31]) + 32'(up);
        end
      end
      FMT_PCM32: begin
        if (neg) begin
          res = ~mag + 32'd1;
        end else begin
          res = p32[62:31] + 32'(p32[30]);
        end
      end
      default: begin
        if (mag != '0) begin
          up = norm[7:0] > 8'h80 || (norm[7:0] == 8'h80 && norm[8]);
          qf = 25'(norm[31:8]) + 25'(up);
          if (qf[24]) begin
            ef  = 8'(expo) + 8'd97;
            res = {neg, ef, 23'h0};
          end else begin
            ef  = 8'(expo) + 8'd96;
            res = {neg, ef, qf[22:0]};
          end
        end
      end
    endcase
    return res;
  endfunction

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // clamp capacity and channel count
  always_comb begin
    if (maxq_q == '0) begin
      cap = CNT_W'(1);
    end else if (maxq_q > CNT_W'(FIFO_DEPTH)) begin
      cap = CNT_W'(FIFO_DEPTH);
    end else begin
      cap = maxq_q;
    end
    if (chans_q == '0) begin
      n_ch = CH_W'(1);
    end else if (chans_q > 4'(MAX_CHANNELS)) begin
      n_ch = CH_W'(MAX_CHANNELS);
    end else begin
      n_ch = CH_W'(chans_q);
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_fmt_q <= FMT_F32;
      chans_q   <= 4'd2;
      ren_fmt_q <= FMT_F32;
      step_q    <= STEP_W'(134217728);
      maxq_q    <= CNT_W'(9600);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_CAPTURE_FORMAT:   cap_fmt_q <= fmt_e'(cfg_i.data[1:0]);
        CFG_CAPTURE_CHANNELS: chans_q   <= cfg_i.data[3:0];
        CFG_RENDER_FORMAT:    ren_fmt_q <= fmt_e'(cfg_i.data[1:0]);
        CFG_STEP_RATIO:       step_q    <= cfg_i.data;
        CFG_MAX_QUEUED:       maxq_q    <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode lanes and merge
  assign words[0] = in_i.chan0_word;
  assign words[1] = in_i.chan1_word;
  assign words[2] = in_i.chan2_word;
  assign words[3] = in_i.chan3_word;
  assign words[4] = in_i.chan4_word;
  assign words[5] = in_i.chan5_word;
  assign words[6] = in_i.chan6_word;
  assign words[7] = in_i.chan7_word;

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    mdlr_lane u_lane (
      .clk_i  (clk_i),
      .load_i (in_acc && !in_i.mode),
      .fmt_i  (cap_fmt_q),
      .word_i (words[g]),
      .val_o  (lane_val[g])
    );
  end

  assign merge_start = (state_q == ST_CAP_SUM);

  mdlr_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (merge_start),
    .silent_i (silent_q),
    .n_i      (n_ch),
    .vals_i   (lane_val),
    .done_o   (merge_done),
    .mono_o   (merge_mono)
  );

  mdlr_ram #(.WIDTH(SAMPLE_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (mono_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign interp_ok = (count_q >= CNT_W'(2)) && (pos_q[POS_W-1:FRAC_W] == '0);
  assign out_load  = (state_q == ST_ENC) && (!out_valid_q || out_o.ready);
  assign nsh       = 6'(5'd16 >> nstep_q);
  assign delta     = prod_q >>> FRAC_W;
  assign enc_word  = encode(ren_fmt_q, neg_q, mag_q, norm_q, expo_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc) state_d = in_i.mode ? ST_R_TRIM : ST_CAP_SUM;
      ST_CAP_SUM:  state_d = ST_CAP_WAIT;
      ST_CAP_WAIT: if (merge_done) state_d = ST_CAP_PUSH;
      ST_CAP_PUSH: state_d = ST_IDLE;
      ST_R_TRIM:   state_d = ST_R_DEBT0;
      ST_R_DEBT0:  state_d = ST_R_CHK;
      ST_R_CHK:    state_d = interp_ok ? ST_R_RD0 : ST_R_ABS;
      ST_R_RD0:    state_d = ST_R_RD1;
      ST_R_RD1:    state_d = ST_R_MUL0;
      ST_R_MUL0:   state_d = ST_R_MUL1;
      ST_R_MUL1:   state_d = ST_R_MUL2;
      ST_R_MUL2:   state_d = ST_R_MUL3;
      ST_R_MUL3:   state_d = ST_R_ADV;
      ST_R_ADV:    state_d = ST_R_DEBT1;
      ST_R_DEBT1:  state_d = ST_R_ABS;
      ST_R_ABS:    state_d = ST_R_NORM;
      ST_R_NORM:   if (nstep_q == 3'(NORM_STEPS - 1)) state_d = ST_ENC;
      ST_ENC:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath per state
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    pos_d    = pos_q;
    peak_d   = peak_q;
    mono_d   = mono_q;
    s0_d     = s0_q;
    sample_d = sample_q;
    diff_d   = diff_q;
    plo_d    = plo_q;
    phi_d    = phi_q;
    prod_d   = prod_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    norm_d   = norm_q;
    expo_d   = expo_q;
    nstep_d  = nstep_q;
    we       = 1'b0;
    raddr    = head_q;
    k        = '0;
    drop     = '0;
    keep_cnt = count_q;
    push_head = head_q;
    pmag     = mono_q[31] ? (~mono_q + 32'd1) : mono_q;
    waddr    = head_q + count_q[ADDR_W-1:0];
    unique case (state_q)
      ST_CAP_WAIT: begin
        if (merge_done) mono_d = merge_mono;
      end
      ST_CAP_PUSH: begin
        // drop oldest when full, then write behind the tail
        if (count_q >= cap) begin
          drop      = count_q - cap + CNT_W'(1);
          push_head = head_q + drop[ADDR_W-1:0];
          keep_cnt  = cap - CNT_W'(1);
        end
        we      = 1'b1;
        waddr   = push_head + keep_cnt[ADDR_W-1:0];
        head_d  = push_head;
        count_d = keep_cnt + CNT_W'(1);
        if (pmag > peak_q) peak_d = pmag;
      end
      ST_R_TRIM: begin
        if (count_q > cap) begin
          head_d  = head_q + ADDR_W'(count_q - cap);
          count_d = cap;
        end
      end
      ST_R_DEBT0: begin
        k       = debt_k(pos_q[POS_W-1:FRAC_W], count_q);
        head_d  = head_q + ADDR_W'(k);
        count_d = count_q - CNT_W'(k);
        pos_d   = pos_q - {k, FRAC_W'(0)};
      end
      ST_R_CHK: begin
        if (!interp_ok) sample_d = '0;
      end
      ST_R_RD0: raddr = head_q;
      ST_R_RD1: begin
        raddr = head_q + ADDR_W'(1);
        s0_d  = rdata;
      end
      ST_R_MUL0: diff_d = $signed({rdata[31], rdata}) - $signed({s0_q[31], s0_q});
      ST_R_MUL1: plo_d  = diff_q[15:0] * pos_q[FRAC_W-1:0];
      ST_R_MUL2: phi_d  = $signed(diff_q[DIFF_W-1:16]) * $signed({1'b0, pos_q[FRAC_W-1:0]});
      ST_R_MUL3: prod_d = (PROD_W'(phi_q) <<< 16) + $signed(PROD_W'(plo_q));
      ST_R_ADV: begin
        sample_d = s0_q + delta[SAMPLE_W-1:0];
        pos_d    = pos_q + POS_W'(step_q);
      end
      ST_R_DEBT1: begin
        k       = debt_k(pos_q[POS_W-1:FRAC_W], count_q - CNT_W'(1));
        head_d  = head_q + ADDR_W'(k);
        count_d = count_q - CNT_W'(k);
        pos_d   = pos_q - {k, FRAC_W'(0)};
      end
      ST_R_ABS: begin
        neg_d   = sample_q[31];
        mag_d   = sample_q[31] ? (~sample_q + 32'd1) : sample_q;
        norm_d  = mag_d;
        expo_d  = 6'd31;
        nstep_d = '0;
      end
      ST_R_NORM: begin
        // shift out leading zeros in halving steps
        if ((norm_q >> (6'd32 - nsh)) == '0) begin
          norm_d = norm_q << nsh;
          expo_d = expo_q - nsh;
        end
        nstep_d = nstep_q + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      peak_q  <= peak_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) silent_q <= in_i.silent;
    mono_q   <= mono_d;
    s0_q     <= s0_d;
    sample_q <= sample_d;
    diff_q   <= diff_d;
    plo_q    <= plo_d;
    phi_q    <= phi_d;
    prod_q   <= prod_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    norm_q   <= norm_d;
    expo_q   <= expo_d;
    nstep_q  <= nstep_d;
    if (out_load) begin
      out_word_q <= enc_word;
      out_peak_q <= peak_q;
      out_cnt_q  <= count_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sample_word  = out_word_q;
  assign out_o.peak_level   = out_peak_q;
  assign out_o.queued_count = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("fifo fill beyond depth");

  a_out_from_enc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_ENC))
    else $error("result raised outside encode");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted beat left no work");

endmodule
`default_nettype wire

### verif/tb_mono_downmix_linear_resampler_core.sv
`timescale 1ns / 1ps
module tb_mono_downmix_linear_resampler_core;
  import mdlr_pkg::*;

  localparam int   ONE_POS_BITS  = 27;
  localparam int   RANDOM_ITEMS  = 1000;
  localparam int   NUM_PHASES    = 8;
  localparam int   SETTLE_CYCLES = 60;
  localparam int   HOLD_CYCLES   = 600;
  localparam logic MODE_CAPTURE  = 1'b0;
  localparam logic MODE_RENDER   = 1'b1;

  typedef struct packed {
    logic [31:0] sample_word;
    logic [31:0] peak_level;
    logic [14:0] queued_count;
  } render_beat_t;

  typedef struct {
    logic         mode;
    logic         silent;
    logic [31:0]  words [8];
    bit           typed;
    render_beat_t result;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mdlr_in_if  in_bus ();
  mdlr_out_if out_bus ();
  mdlr_cfg_if cfg_bus ();

  mono_downmix_linear_resampler_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the block's registers and state
  fmt_e               cap_fmt;
  logic [3:0]         cap_chans;
  fmt_e               ren_fmt;
  logic [31:0]        step_q527;
  logic [14:0]        queue_limit;
  logic [31:0]        mono_store [FIFO_DEPTH];
  int unsigned        store_head;
  int unsigned        store_fill;
  longint unsigned    read_pos;
  logic [31:0]        peak_mag;

  render_beat_t       pending_renders [$];
  int                 errors = 0;
  int                 sender_idle_pct = 0;
  int                 stall_pct = 0;
  bit                 hold_req = 1'b0;
  int                 hold_cnt = 0;
  bit                 cur_typed = 1'b0;
  render_beat_t       cur_result;
  frame_t             directed [$];

  function automatic logic signed [31:0] float_to_q31(logic [31:0] w);
    logic [7:0]      ex;
    longint unsigned man;
    longint unsigned mag;
    int              sh;
    ex  = w[30:23];
    man = 64'(w[22:0]);
    if (ex == 8'hFF && man != 0) return 32'sd0;
    if (ex == 8'h00) return 32'sd0;
    if (ex == 8'hFF) begin
      mag = 64'd1 << 32;
    end else begin
      man = man | 64'h80_0000;
      sh  = int'(ex) - 119;
      if (sh > 8) mag = 64'd1 << 32;
      else if (sh >= 0) mag = man << sh;
      else if (sh > -32) mag = man >> (-sh);
      else mag = 64'd0;
    end
    if (w[31]) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-longint'(mag));
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic logic signed [31:0] decode_word(logic [31:0] w);
    case (cap_fmt)
      FMT_PCM16: return {w[15:0], 16'h0};
      FMT_PCM24: return {w[23:0], 8'h0};
      FMT_PCM32: return w;
      default:   return float_to_q31(w);
    endcase
  endfunction

  function automatic longint unsigned round_even(longint unsigned v, int sh);
    longint unsigned q;
    longint unsigned r;
    longint unsigned half;
    q    = v >> sh;
    r    = v & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (r > half || (r == half && q[0])) q++;
    return q;
  endfunction

  function automatic logic [31:0] q31_to_float(logic signed [31:0] x);
    longint unsigned mag;
    longint unsigned m;
    int unsigned     p;
    if (x == 0) return 32'h0;
    mag = (x < 0) ? 64'(-longint'(x)) : 64'(x);
    p = 0;
    while (p < 31 && (mag >> (p + 1)) != 0) p++;
    if (p <= 23) begin
      m = mag << (23 - p);
    end else begin
      m = round_even(mag, p - 23);
      if ((m >> 24) != 0) begin
        m = m >> 1;
        p++;
      end
    end
    return {x[31], 8'(p + 96), m[22:0]};
  endfunction

  function automatic logic [31:0] encode_sample(logic signed [31:0] x);
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned q;
    mag = (x < 0) ? 64'(-longint'(x)) : 64'(x);
    case (ren_fmt)
      FMT_PCM16: begin
        if (x < 0) return 32'(64'd0 - round_even(mag, 16)) & 32'hFFFF;
        return 32'(round_even(mag * 32767, 31));
      end
      FMT_PCM24: begin
        if (x < 0) return 32'(64'd0 - round_even(mag, 8)) & 32'hFF_FFFF;
        return 32'(round_even(mag * 8388607, 31));
      end
      FMT_PCM32: begin
        if (x < 0) return 32'(64'd0 - mag);
        prod = mag * 64'd2147483647;
        q    = prod >> 31;
        if ((prod & 64'h7FFF_FFFF) >= 64'h4000_0000) q++;
        return 32'(q);
      end
      default: return q31_to_float(x);
    endcase
  endfunction

  function automatic logic signed [31:0] stored_at(int unsigned i);
    return mono_store[(store_head + i) % FIFO_DEPTH];
  endfunction

  function automatic void drop_oldest(int unsigned k);
    store_head = (store_head + k) % FIFO_DEPTH;
    store_fill = store_fill - k;
  endfunction

  function automatic void settle_position(int unsigned keep);
    longint unsigned owed;
    int unsigned     avail;
    owed  = read_pos >> ONE_POS_BITS;
    avail = (store_fill > keep) ? store_fill - keep : 0;
    if (owed > avail) owed = avail;
    drop_oldest(int'(owed));
    read_pos = read_pos - (owed << ONE_POS_BITS);
  endfunction

  // Advance the shadow state by one frame; return 1 if it renders a sample
  function automatic bit resample_frame(frame_t f, output render_beat_t res);
    int unsigned        cap;
    int unsigned        n;
    longint             acc;
    longint             mono;
    longint unsigned    mag;
    longint             s0;
    longint             s1;
    logic signed [31:0] smp;
    cap = (queue_limit < 1) ? 1 : ((queue_limit > FIFO_DEPTH) ? FIFO_DEPTH : queue_limit);
    res = '0;
    if (f.mode == MODE_CAPTURE) begin
      mono = 0;
      if (!f.silent) begin
        n = (cap_chans < 1) ? 1 : ((cap_chans > MAX_CHANNELS) ? MAX_CHANNELS : cap_chans);
        acc = 0;
        for (int c = 0; c < n; c++) acc += longint'(decode_word(f.words[c]));
        mono = acc / longint'(n);
      end
      mag = (mono < 0) ? 64'(-mono) : 64'(mono);
      if (mag > 64'(peak_mag)) peak_mag = mag[31:0];
      if (store_fill >= cap) drop_oldest(store_fill - cap + 1);
      mono_store[(store_head + store_fill) % FIFO_DEPTH] = mono[31:0];
      store_fill++;
      return 1'b0;
    end
    smp = 0;
    if (store_fill > cap) drop_oldest(store_fill - cap);
    settle_position(0);
    if (store_fill >= 2 && read_pos < (64'd1 << ONE_POS_BITS)) begin
      s0  = longint'(stored_at(0));
      s1  = longint'(stored_at(1));
      smp = 32'(s0 + (((s1 - s0) * longint'(read_pos)) >>> ONE_POS_BITS));
      read_pos = read_pos + 64'(step_q527);
      settle_position(1);
    end
    res.sample_word  = encode_sample(smp);
    res.peak_level   = peak_mag;
    res.queued_count = store_fill[14:0];
    return 1'b1;
  endfunction

  // Record every accepted frame in the shadow model
  always @(posedge clk_i) begin
    frame_t       f;
    render_beat_t res;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      f.mode   = in_bus.mode;
      f.silent = in_bus.silent;
      f.words  = '{in_bus.chan0_word, in_bus.chan1_word, in_bus.chan2_word,
                   in_bus.chan3_word, in_bus.chan4_word, in_bus.chan5_word,
                   in_bus.chan6_word, in_bus.chan7_word};
      if (resample_frame(f, res)) begin
        pending_renders.insert(pending_renders.size(), cur_typed ? cur_result : res);
      end
    end
  end

  // Compare each render beat against the oldest pending one
  always @(posedge clk_i) begin
    render_beat_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_renders.size() == 0) begin
        errors++;
        $display("%0t: unexpected render beat %h/%h/%h", $time, out_bus.sample_word,
                 out_bus.peak_level, out_bus.queued_count);
      end else begin
        want = pending_renders[0];
        pending_renders.delete(0);
        if (out_bus.sample_word !== want.sample_word) begin
          errors++;
          $display("%0t: sample_word expected %h actual %h", $time, want.sample_word,
                   out_bus.sample_word);
        end
        if (out_bus.peak_level !== want.peak_level) begin
          errors++;
          $display("%0t: peak_level expected %h actual %h", $time, want.peak_level,
                   out_bus.peak_level);
        end
        if (out_bus.queued_count !== want.queued_count) begin
          errors++;
          $display("%0t: queued_count expected %0d actual %0d", $time, want.queued_count,
                   out_bus.queued_count);
        end
      end
    end
  end

  // Drive output ready; a hold-off request blocks it for a long stretch
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_bus.ready = 1'b0;
    end else begin
      out_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.mode       = f.mode;
    in_bus.silent     = f.silent;
    in_bus.chan0_word = f.words[0];
    in_bus.chan1_word = f.words[1];
    in_bus.chan2_word = f.words[2];
    in_bus.chan3_word = f.words[3];
    in_bus.chan4_word = f.words[4];
    in_bus.chan5_word = f.words[5];
    in_bus.chan6_word = f.words[6];
    in_bus.chan7_word = f.words[7];
    cur_typed         = f.typed;
    cur_result        = f.result;
    in_bus.valid      = 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    cfg_bus.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
    case (idx)
      CFG_CAPTURE_FORMAT:   cap_fmt     = fmt_e'(value[1:0]);
      CFG_CAPTURE_CHANNELS: cap_chans   = value[3:0];
      CFG_RENDER_FORMAT:    ren_fmt     = fmt_e'(value[1:0]);
      CFG_STEP_RATIO:       step_q527   = value;
      CFG_MAX_QUEUED:       queue_limit = value[14:0];
      default: ;
    endcase
  endtask

  // Wait for every render beat, then let a capture still in flight finish
  task automatic drain();
    in_bus.valid = 1'b0;
    while (pending_renders.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic add_row(logic mode, logic silent, logic [31:0] w0, logic [31:0] w1,
                         bit typed, render_beat_t res);
    frame_t f;
    f.mode   = mode;
    f.silent = silent;
    for (int c = 0; c < 8; c++) f.words[c] = c[0] ? w1 : w0;
    f.typed  = typed;
    f.result = res;
    directed.insert(directed.size(), f);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] specials [10];
    specials = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_8000, 32'h0000_7FFF,
                 32'h7F80_0000, 32'h7FC0_0000, 32'h4F00_0000, 32'h3F80_0000,
                 32'hFF80_0000, 32'h0080_0000};
    if ($urandom_range(99) < 70) return $urandom;
    return specials[$urandom_range(9)];
  endfunction

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    frame_t f;
    int     per_phase;
    logic [31:0] ratio;
    logic [31:0] limit;
    logic [1:0]  cfmt;
    logic [1:0]  rfmt;
    logic [3:0]  nch;

    in_bus.valid = 1'b0;
    in_bus.mode = MODE_CAPTURE;
    in_bus.silent = 1'b0;
    in_bus.chan0_word = '0;
    in_bus.chan1_word = '0;
    in_bus.chan2_word = '0;
    in_bus.chan3_word = '0;
    in_bus.chan4_word = '0;
    in_bus.chan5_word = '0;
    in_bus.chan6_word = '0;
    in_bus.chan7_word = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_CAPTURE_FORMAT;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;

    cap_fmt     = FMT_F32;
    cap_chans   = 4'd2;
    ren_fmt     = FMT_F32;
    step_q527   = 32'h0800_0000;
    queue_limit = 15'd9600;
    store_head  = 0;
    store_fill  = 0;
    read_pos    = 0;
    peak_mag    = '0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames under the reset settings
    add_row(MODE_RENDER, 1'b0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 15'd0});
    add_row(MODE_CAPTURE, 1'b0, 32'h7F80_0000, 32'h7F80_0000, 1'b0, '0);
    add_row(MODE_CAPTURE, 1'b0, 32'hFF80_0000, 32'hFF80_0000, 1'b0, '0);
    add_row(MODE_RENDER, 1'b0, 32'h0, 32'h0, 1'b1, '{32'h3F80_0000, 32'h8000_0000, 15'd1});
    add_row(MODE_CAPTURE, 1'b0, 32'h7FC0_0000, 32'h3F00_0000, 1'b0, '0);
    add_row(MODE_CAPTURE, 1'b0, 32'h0000_0001, 32'h807F_FFFF, 1'b0, '0);
    add_row(MODE_CAPTURE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(MODE_CAPTURE, 1'b0, 32'hBF00_0000, 32'h3E80_0000, 1'b0, '0);
    add_row(MODE_RENDER, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '0);
    add_row(MODE_RENDER, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(MODE_CAPTURE, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(MODE_CAPTURE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(MODE_CAPTURE, 1'b0, 32'h4F00_0000, 32'h3F80_0000, 1'b0, '0);
    add_row(MODE_RENDER, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(MODE_RENDER, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(MODE_RENDER, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    add_row(MODE_RENDER, 1'b0, 32'h0, 32'h0, 1'b0, '0);
    foreach (directed[i]) send_frame(directed[i]);
    drain();

    // Random phases, each under its own register setting and one of four idle patterns
    per_phase = RANDOM_ITEMS / NUM_PHASES;
    f.typed   = 1'b0;
    f.result  = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin cfmt = 2'd0; nch = 4'd1;  rfmt = 2'd0; ratio = 32'h0400_0000; limit = 2;     end
        1: begin cfmt = 2'd1; nch = 4'd8;  rfmt = 2'd1; ratio = 32'h0C00_0000; limit = 16384; end
        2: begin cfmt = 2'd2; nch = 4'd15; rfmt = 2'd2; ratio = 32'h0;         limit = 0;     end
        3: begin cfmt = 2'd3; nch = 4'd0;  rfmt = 2'd3; ratio = 32'hFFFF_FFFF; limit = 32767; end
        default: begin
          cfmt  = 2'($urandom_range(3));
          nch   = 4'($urandom_range(15));
          rfmt  = 2'($urandom_range(3));
          ratio = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h0400_0000,
                                                                        32'h1800_0000);
          limit = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 40);
        end
      endcase
      write_reg(CFG_CAPTURE_FORMAT, {30'h0, cfmt});
      write_reg(CFG_CAPTURE_CHANNELS, {28'h0, nch});
      write_reg(CFG_RENDER_FORMAT, {30'h0, rfmt});
      write_reg(CFG_STEP_RATIO, ratio);
      write_reg(CFG_MAX_QUEUED, limit);

      case (ph % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 61; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 61; end
        default: begin sender_idle_pct = 37; stall_pct = 37; end
      endcase
      // Block the receiver early in one phase so the core backs up
      if (ph == 1) hold_req = 1'b1;

      for (int k = 0; k < per_phase; k++) begin
        f.mode   = ($urandom_range(99) < 45) ? MODE_RENDER : MODE_CAPTURE;
        f.silent = ($urandom_range(9) == 0);
        for (int c = 0; c < 8; c++) f.words[c] = pick_word();
        send_frame(f);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### mono_downmix_linear_resampler_core.f
src/mdlr_pkg.sv
src/mdlr_if.sv
src/mdlr_ram.sv
src/mdlr_lane.sv
src/mdlr_merge.sv
src/mono_downmix_linear_resampler_core.sv
verif/tb_mono_downmix_linear_resampler_core.sv
